[sv/hmst_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers for the hh:mm:ss up/down timer.
// No dependencies; imported by every timer module.
package hmst_pkg;

  localparam logic [15:0] MS_PER_SEC = 16'd1000;
  localparam logic [15:0] ACCUM_MAX  = 16'hFFFF;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED    = 2'd0,
    CFG_COUNT_DOWN = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [9:0]        elapsed_ms;
    logic signed [7:0] set_hours;
    logic signed [7:0] set_minutes;
    logic signed [7:0] set_seconds;
  } item_t;

  typedef struct packed {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [15:0] accum;
  } hms_state_t;

  typedef struct packed {
    logic enabled;
    logic count_down;
  } cfg_t;

  // Quotient by 60 for values up to 179.
  function automatic logic [1:0] div60(input logic [7:0] v);
    logic [1:0] q;
    if (v >= 8'd120) q = 2'd2;
    else if (v >= 8'd60) q = 2'd1;
    else q = 2'd0;
    return q;
  endfunction

  // Remainder by 60 given the quotient from div60.
  function automatic logic [5:0] rem60(input logic [7:0] v, input logic [1:0] q);
    logic [7:0] r;
    case (q)
      2'd2:    r = v - 8'd120;
      2'd1:    r = v - 8'd60;
      default: r = v;
    endcase
    return r[5:0];
  endfunction

  // Remainder by 24 for values up to 143.
  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] r;
    if (v >= 8'd120) r = v - 8'd120;
    else if (v >= 8'd96) r = v - 8'd96;
    else if (v >= 8'd72) r = v - 8'd72;
    else if (v >= 8'd48) r = v - 8'd48;
    else if (v >= 8'd24) r = v - 8'd24;
    else r = v;
    return r[4:0];
  endfunction

endpackage

[sv/hmst_in_reg.sv]
`timescale 1ns / 1ps
// Input holding register: captures one word and keeps it until the
// update stage pops it. Depends on hmst_pkg.
module hmst_in_reg import hmst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign in_ready_o = !valid_q || pop_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) valid_d = 1'b1;
    else if (pop_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/hmst_step.sv]
`timescale 1ns / 1ps
// Next-state logic for one word: tick, set or clear.
// Pure combinational; depends on hmst_pkg.
module hmst_step import hmst_pkg::*; (
  input  item_t      item_i,
  input  hms_state_t cur_i,
  input  cfg_t       cfg_i,
  output hms_state_t nxt_o,
  output logic       stepped_o
);

  logic [16:0] sum;
  logic [15:0] acc_sat;
  logic        at_zero;
  logic        step_ok;
  hms_state_t  up, dn;
  logic [1:0]  q_s, q_m;
  logic [7:0]  m_w, h_w;
  logic        set_neg;

  always_comb begin
    sum     = {1'b0, cur_i.accum} + 17'(item_i.elapsed_ms);
    acc_sat = sum[16] ? ACCUM_MAX : sum[15:0];
    at_zero = (cur_i.hours == 5'd0) && (cur_i.minutes == 6'd0) && (cur_i.seconds == 6'd0);
    step_ok = cfg_i.enabled && !(cfg_i.count_down && at_zero) && (acc_sat >= MS_PER_SEC);

    // count up, wrap at 24h
    up = cur_i;
    if (cur_i.seconds == 6'd59) begin
      up.seconds = 6'd0;
      if (cur_i.minutes == 6'd59) begin
        up.minutes = 6'd0;
        up.hours   = (cur_i.hours >= 5'd23) ? 5'd0 : cur_i.hours + 5'd1;
      end else begin
        up.minutes = cur_i.minutes + 6'd1;
      end
    end else begin
      up.seconds = cur_i.seconds + 6'd1;
    end

    // count down with borrow
    dn = cur_i;
    if (cur_i.seconds != 6'd0) begin
      dn.seconds = cur_i.seconds - 6'd1;
    end else begin
      dn.seconds = 6'd59;
      if (cur_i.minutes != 6'd0) begin
        dn.minutes = cur_i.minutes - 6'd1;
      end else begin
        dn.minutes = 6'd59;
        if (cur_i.hours != 5'd0) dn.hours = cur_i.hours - 5'd1;
      end
    end

    // set: carry seconds -> minutes -> hours, hours mod 24
    set_neg = item_i.set_hours[7] || item_i.set_minutes[7] || item_i.set_seconds[7];
    q_s = div60({1'b0, item_i.set_seconds[6:0]});
    m_w = {1'b0, item_i.set_minutes[6:0]} + 8'(q_s);
    q_m = div60(m_w);
    h_w = {1'b0, item_i.set_hours[6:0]} + 8'(q_m);

    nxt_o     = cur_i;
    stepped_o = 1'b0;
    case (func_e'(item_i.func))
      FUNC_TICK: begin
        nxt_o.accum = acc_sat;
        if (step_ok) begin
          nxt_o       = cfg_i.count_down ? dn : up;
          nxt_o.accum = acc_sat - MS_PER_SEC;
          stepped_o   = 1'b1;
        end
      end
      FUNC_SET: begin
        if (!set_neg) begin
          nxt_o.seconds = rem60({1'b0, item_i.set_seconds[6:0]}, q_s);
          nxt_o.minutes = rem60(m_w, q_m);
          nxt_o.hours   = mod24(h_w);
          nxt_o.accum   = 16'd0;
        end
      end
      FUNC_CLEAR: begin
        nxt_o = '0;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

[sv/hms_up_down_timer_core.sv]
`timescale 1ns / 1ps
// Top level of the hh:mm:ss up/down timer with millisecond accumulator.
// Depends on hmst_pkg, hmst_in_reg and hmst_step.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o) carries one command word: tick
//   with elapsed milliseconds, set time, or clear. Unused func code is a
//   no-op that still returns the current time.
// - Output channel (out_valid_o/out_ready_i) returns exactly one word per
//   command: stepped flag, hours, minutes, seconds, accumulator.
// - Config channel (cfg_valid_i/cfg_ready_o) writes enabled (index 0) and
//   count_down (index 1); other indexes are dropped. Always ready; write
//   only while no command is in flight.
// - Order: an accepted word waits in the input register until the update
//   stage fires, which writes state and the result register together;
//   out_valid_o rises once the result register is loaded.
// - Throughput: one word per cycle unless stalled; time/accumulator update is
//   a single short step, so back-to-back words chain through state registers.
// - Receiver stall: the result register holds; the input register still
//   takes one more word, then in_ready_o drops until the result drains.
// - Reset: time, accumulator and config clear to zero, both stages empty.
module hms_up_down_timer_core import hmst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  logic [9:0]           elapsed_ms_i,
  input  logic signed [7:0]    set_hours_i,
  input  logic signed [7:0]    set_minutes_i,
  input  logic signed [7:0]    set_seconds_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 stepped_o,
  output logic [4:0]           hours_o,
  output logic [5:0]           minutes_o,
  output logic [5:0]           seconds_o,
  output logic [15:0]          msec_accum_o,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_wdata_i
);

  item_t      in_item, cur_item;
  logic       cur_valid;
  logic       adv;
  hms_state_t state_q, state_d;
  cfg_t       cfg_q;
  logic       stepped_d;
  logic       out_valid_q;
  logic       stepped_q;
  hms_state_t res_q;

  assign in_item = '{func:        func_i,
                     elapsed_ms:  elapsed_ms_i,
                     set_hours:   set_hours_i,
                     set_minutes: set_minutes_i,
                     set_seconds: set_seconds_i};

  // update stage fires when a word is held and the result slot is free
  assign adv = cur_valid && (!out_valid_q || out_ready_i);

  hmst_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .pop_i      (adv),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  hmst_step u_step (
    .item_i    (cur_item),
    .cur_i     (state_q),
    .cfg_i     (cfg_q),
    .nxt_o     (state_d),
    .stepped_o (stepped_d)
  );

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLED:    cfg_q.enabled    <= cfg_wdata_i;
        CFG_COUNT_DOWN: cfg_q.count_down <= cfg_wdata_i;
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  // time state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        state_q <= state_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q     <= state_d;
      stepped_q <= stepped_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign stepped_o    = stepped_q;
  assign hours_o      = res_q.hours;
  assign minutes_o    = res_q.minutes;
  assign seconds_o    = res_q.seconds;
  assign msec_accum_o = res_q.accum;

  // reported time always in range
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (seconds_o < 6'd60) && (minutes_o < 6'd60) && (hours_o < 5'd24))
    else $error("time out of range");

  // a step only happens when enabled
  a_step_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && stepped_d |-> cfg_q.enabled)
    else $error("step while disabled");

  // held word is not dropped while the result slot is busy
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid && !adv |=> cur_valid)
    else $error("held word lost");

  // every update produces a result
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("result not loaded");

endmodule
